[design/sn2d_pkg.sv]
// ----------------------------------------------------------------------------
// sn2d_pkg
// Constants, permutation table and gradient helper for the 2D simplex noise
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sn2d_pkg;

  localparam int WQ        = 30;
  localparam int CELL_BITS = 8;
  localparam int NSTAGE    = 15;

  localparam logic signed [31:0] SKEW_Q30    = 32'sd393016785;
  localparam logic signed [31:0] UNSKEW_Q30  = 32'sd226908346;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [31:0] HALF_Q30    = 32'sd536870912;
  localparam logic signed [31:0] CORNER2_OFS = -32'sd619925132;
  localparam logic signed [31:0] ROUND_Q14   = 32'sd32768;
  localparam logic signed [7:0]  NOISE_SCALE = 8'sd70;
  localparam logic signed [22:0] OUT_MAX     = 23'sd16384;

  localparam logic signed [1:0] GRAD_X [8] = '{
    2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0
  };
  localparam logic signed [1:0] GRAD_Y [8] = '{
    2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1
  };

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic signed [32:0] grad_dot(input logic [2:0] gi,
                                                  input logic signed [31:0] dx,
                                                  input logic signed [31:0] dy);
    logic signed [32:0] ex;
    logic signed [32:0] ey;
    logic signed [32:0] tx;
    logic signed [32:0] ty;
    ex = 33'(dx);
    ey = 33'(dy);
    tx = (GRAD_X[gi] == 2'sd0) ? 33'sd0 : (GRAD_X[gi][1] ? -ex : ex);
    ty = (GRAD_Y[gi] == 2'sd0) ? 33'sd0 : (GRAD_Y[gi][1] ? -ey : ey);
    return tx + ty;
  endfunction

endpackage

`default_nettype wire

[design/simplex_noise_2d_unit.sv]
// ----------------------------------------------------------------------------
// simplex_noise_2d_unit
// Pipelined 2D simplex noise: signed fixed-point point in, Q2.14 noise out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one point (in_x_coord,
//   in_y_coord), signed, FRAC_BITS fraction bits. Output channel
//   out_valid/out_ready carries out_noise_value, signed Q2.14, saturated to
//   [-16384, 16384]. Every input transfer yields exactly one output, in order.
//   The datapath is a 15-stage pipeline; the last stage is the output
//   register. Throughput is one point per cycle while the receiver
//   takes outputs. Each stage holds a valid bit and loads whenever
//   out_ready is high or it or any later stage is empty, so bubbles
//   collapse and a stalled receiver stops only the filled tail of the
//   pipeline; in_ready drops only when all 15 stages are full and
//   out_ready is low.
//   Synchronous active-low reset clears all valid bits; data registers are
//   not reset. No configuration, no internal state between points.
// ----------------------------------------------------------------------------
`default_nettype none

module simplex_noise_2d_unit
  import sn2d_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_x_coord,
  input  wire logic signed [31:0] in_y_coord,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_noise_value
);

  localparam int TB  = FRAC_BITS + WQ;
  localparam int XSW = TB + CELL_BITS;

  logic [NSTAGE:1] vld_r;
  logic [NSTAGE:1] vld_nxt;
  logic [NSTAGE:1] en;

  // stage 1
  logic signed [31:0] s1_x_r, s1_y_r;
  logic signed [32:0] s1_sum_r, s1_sum_nxt;
  // stage 2
  logic signed [31:0] s2_x_r, s2_y_r;
  logic signed [63:0] s2_skew_r, s2_skew_nxt;
  // stage 3
  logic [XSW-1:0] s3_xs_r, s3_ys_r, s3_xs_nxt, s3_ys_nxt;
  // stage 4
  logic [7:0]  s4_ci_r, s4_hj0_r, s4_hj1_r, s4_ci_nxt, s4_hj0_nxt, s4_hj1_nxt;
  logic        s4_oi_r, s4_oi_nxt;
  logic [29:0] s4_fx_r, s4_fy_r, s4_fx_nxt, s4_fy_nxt;
  logic [30:0] s4_fsum_r, s4_fsum_nxt;
  // stage 5
  logic [58:0] s5_gprod_r, s5_gprod_nxt;
  logic [29:0] s5_fx_r, s5_fy_r;
  logic        s5_oi_r;
  logic [2:0]  s5_gi_r [3];
  logic [2:0]  s5_gi_nxt [3];
  // stage 6
  logic [29:0] s6_g_r, s6_g_nxt;
  logic [29:0] s6_fx_r, s6_fy_r;
  logic        s6_oi_r;
  logic [2:0]  s6_gi_r [3];
  // stage 7
  logic signed [31:0] s7_dx_r [3];
  logic signed [31:0] s7_dy_r [3];
  logic signed [31:0] s7_dx_nxt [3];
  logic signed [31:0] s7_dy_nxt [3];
  logic [2:0]         s7_gi_r [3];
  // stage 8
  logic [61:0]        s8_sqx_r [3];
  logic [61:0]        s8_sqy_r [3];
  logic [61:0]        s8_sqx_nxt [3];
  logic [61:0]        s8_sqy_nxt [3];
  logic signed [32:0] s8_d_r [3];
  logic signed [32:0] s8_d_nxt [3];
  // stage 9
  logic [29:0]        s9_t_r [3];
  logic [29:0]        s9_t_nxt [3];
  logic signed [32:0] s9_d_r [3];
  // stage 10
  logic [59:0]        s10_tt_r [3];
  logic [59:0]        s10_tt_nxt [3];
  logic signed [32:0] s10_d_r [3];
  // stage 11
  logic [57:0]        s11_tt_r [3];
  logic [57:0]        s11_tt_nxt [3];
  logic signed [32:0] s11_d_r [3];
  // stage 12
  logic signed [59:0] s12_cd_r [3];
  logic signed [59:0] s12_cd_nxt [3];
  // stage 13
  logic signed [31:0] s13_sum_r, s13_sum_nxt;
  // stage 14
  logic signed [38:0] s14_scaled_r, s14_scaled_nxt;
  // stage 15
  logic signed [15:0] s15_noise_r, s15_noise_nxt;

  // Pipeline control: a stage loads when out_ready is high or it or any later stage is free.
  always_comb begin
    for (int k = 1; k <= NSTAGE; k++) begin
      en[k] = out_ready;
      for (int m = k; m <= NSTAGE; m++) begin
        en[k] = en[k] | ~vld_r[m];
      end
    end
    vld_nxt = vld_r;
    if (en[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NSTAGE; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready        = en[1];
  assign out_valid       = vld_r[NSTAGE];
  assign out_noise_value = s15_noise_r;

  // Stage 1-3: sum the coordinates and skew them.
  always_comb begin
    s1_sum_nxt  = 33'(in_x_coord) + 33'(in_y_coord);
    s2_skew_nxt = 64'(s1_sum_r) * 64'(SKEW_Q30);
    s3_xs_nxt   = XSW'({s2_x_r, {WQ{1'b0}}}) + XSW'(s2_skew_r);
    s3_ys_nxt   = XSW'({s2_y_r, {WQ{1'b0}}}) + XSW'(s2_skew_r);
  end

  // Stage 4: split into cell and fraction, triangle select, first hash level.
  always_comb begin
    s4_ci_nxt   = s3_xs_r[XSW-1 -: CELL_BITS];
    s4_hj0_nxt  = PERM[s3_ys_r[XSW-1 -: CELL_BITS]];
    s4_hj1_nxt  = PERM[s3_ys_r[XSW-1 -: CELL_BITS] + 8'd1];
    s4_oi_nxt   = s3_xs_r[TB-1:0] > s3_ys_r[TB-1:0];
    s4_fx_nxt   = s3_xs_r[TB-1 -: WQ];
    s4_fy_nxt   = s3_ys_r[TB-1 -: WQ];
    s4_fsum_nxt = {1'b0, s4_fx_nxt} + {1'b0, s4_fy_nxt};
  end

  // Stage 5: unskew product, second hash level.
  always_comb begin
    logic [7:0] hj_mid;
    hj_mid       = s4_oi_r ? s4_hj0_r : s4_hj1_r;
    s5_gprod_nxt = 59'(s4_fsum_r) * 59'(UNSKEW_Q30);
    s5_gi_nxt[0] = PERM[s4_ci_r + s4_hj0_r][2:0];
    s5_gi_nxt[1] = PERM[s4_ci_r + {7'd0, s4_oi_r} + hj_mid][2:0];
    s5_gi_nxt[2] = PERM[s4_ci_r + 8'd1 + s4_hj1_r][2:0];
  end

  // Stage 6-7: round unskew, form corner offsets.
  always_comb begin
    logic [58:0]        gr;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    gr       = s5_gprod_r + 59'(HALF_Q30);
    s6_g_nxt = {1'b0, gr[58:WQ]};
    x0 = signed'({2'b00, s6_fx_r}) - signed'({2'b00, s6_g_r});
    y0 = signed'({2'b00, s6_fy_r}) - signed'({2'b00, s6_g_r});
    s7_dx_nxt[0] = x0;
    s7_dy_nxt[0] = y0;
    s7_dx_nxt[1] = x0 + UNSKEW_Q30 - (s6_oi_r ? ONE_Q30 : 32'sd0);
    s7_dy_nxt[1] = y0 + UNSKEW_Q30 - (s6_oi_r ? 32'sd0 : ONE_Q30);
    s7_dx_nxt[2] = x0 + CORNER2_OFS;
    s7_dy_nxt[2] = y0 + CORNER2_OFS;
  end

  // Stage 8-12: falloff and gradient contribution per corner lane.
  always_comb begin
    logic [62:0]        rx;
    logic [62:0]        ry;
    logic signed [34:0] t;
    logic [59:0]        r10;
    logic [57:0]        r11;
    for (int c = 0; c < 3; c++) begin
      s8_sqx_nxt[c] = 62'(64'(s7_dx_r[c]) * 64'(s7_dx_r[c]));
      s8_sqy_nxt[c] = 62'(64'(s7_dy_r[c]) * 64'(s7_dy_r[c]));
      s8_d_nxt[c]   = grad_dot(s7_gi_r[c], s7_dx_r[c], s7_dy_r[c]);
      rx = 63'(s8_sqx_r[c]) + 63'(HALF_Q30);
      ry = 63'(s8_sqy_r[c]) + 63'(HALF_Q30);
      t  = 35'(HALF_Q30) - signed'({2'b00, rx[62:WQ]}) - signed'({2'b00, ry[62:WQ]});
      s9_t_nxt[c]   = t[34] ? 30'd0 : t[29:0];
      s10_tt_nxt[c] = 60'(s9_t_r[c]) * 60'(s9_t_r[c]);
      r10 = s10_tt_r[c] + 60'(HALF_Q30);
      s11_tt_nxt[c] = 58'(r10[58:WQ]) * 58'(r10[58:WQ]);
      r11 = s11_tt_r[c] + 58'(HALF_Q30);
      s12_cd_nxt[c] = 60'(signed'({1'b0, r11[56:WQ]})) * 60'(s11_d_r[c]);
    end
  end

  // Stage 13-15: sum corners, scale, round and saturate.
  always_comb begin
    logic signed [59:0] cr [3];
    logic signed [38:0] rs;
    logic signed [22:0] r;
    for (int c = 0; c < 3; c++) begin
      cr[c] = s12_cd_r[c] + 60'(HALF_Q30);
    end
    s13_sum_nxt = 32'(signed'(cr[0][59:WQ])) + 32'(signed'(cr[1][59:WQ]))
                + 32'(signed'(cr[2][59:WQ]));
    s14_scaled_nxt = 39'(s13_sum_r) * 39'(NOISE_SCALE);
    rs = s14_scaled_r + 39'(ROUND_Q14);
    r  = signed'(rs[38:16]);
    if (r > OUT_MAX) begin
      s15_noise_nxt = 16'(OUT_MAX);
    end else if (r < -OUT_MAX) begin
      s15_noise_nxt = 16'(-OUT_MAX);
    end else begin
      s15_noise_nxt = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_x_r   <= in_x_coord;
      s1_y_r   <= in_y_coord;
      s1_sum_r <= s1_sum_nxt;
    end
    if (en[2]) begin
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_skew_r <= s2_skew_nxt;
    end
    if (en[3]) begin
      s3_xs_r <= s3_xs_nxt;
      s3_ys_r <= s3_ys_nxt;
    end
    if (en[4]) begin
      s4_ci_r   <= s4_ci_nxt;
      s4_hj0_r  <= s4_hj0_nxt;
      s4_hj1_r  <= s4_hj1_nxt;
      s4_oi_r   <= s4_oi_nxt;
      s4_fx_r   <= s4_fx_nxt;
      s4_fy_r   <= s4_fy_nxt;
      s4_fsum_r <= s4_fsum_nxt;
    end
    if (en[5]) begin
      s5_gprod_r <= s5_gprod_nxt;
      s5_fx_r    <= s4_fx_r;
      s5_fy_r    <= s4_fy_r;
      s5_oi_r    <= s4_oi_r;
      s5_gi_r    <= s5_gi_nxt;
    end
    if (en[6]) begin
      s6_g_r  <= s6_g_nxt;
      s6_fx_r <= s5_fx_r;
      s6_fy_r <= s5_fy_r;
      s6_oi_r <= s5_oi_r;
      s6_gi_r <= s5_gi_r;
    end
    if (en[7]) begin
      s7_dx_r <= s7_dx_nxt;
      s7_dy_r <= s7_dy_nxt;
      s7_gi_r <= s6_gi_r;
    end
    if (en[8]) begin
      s8_sqx_r <= s8_sqx_nxt;
      s8_sqy_r <= s8_sqy_nxt;
      s8_d_r   <= s8_d_nxt;
    end
    if (en[9]) begin
      s9_t_r <= s9_t_nxt;
      s9_d_r <= s8_d_r;
    end
    if (en[10]) begin
      s10_tt_r <= s10_tt_nxt;
      s10_d_r  <= s9_d_r;
    end
    if (en[11]) begin
      s11_tt_r <= s11_tt_nxt;
      s11_d_r  <= s10_d_r;
    end
    if (en[12]) begin
      s12_cd_r <= s12_cd_nxt;
    end
    if (en[13]) begin
      s13_sum_r <= s13_sum_nxt;
    end
    if (en[14]) begin
      s14_scaled_r <= s14_scaled_nxt;
    end
    if (en[15]) begin
      s15_noise_r <= s15_noise_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_noise_value <= 16'sd16384) && (out_noise_value >= -16'sd16384))
    else $error("noise output outside saturation range");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[1])
    else $error("accepted point did not enter stage 1");

  a_falloff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[9] |-> (s9_t_r[0] <= 30'd536870912) && (s9_t_r[1] <= 30'd536870912)
                 && (s9_t_r[2] <= 30'd536870912))
    else $error("falloff term above one half");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire
